// ===== hw/rtl/bale_pkg.sv =====
// shared types and codes for the bounded array list engine
`timescale 1ns / 1ps
`default_nettype none

package bale_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_POP_BACK   = 3'd1,
      OP_PUSH_FRONT = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4,
      OP_ERASE      = 3'd5,
      OP_FIND       = 3'd6,
      OP_REMOVE     = 3'd7
   } op_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_FULL     = 3'd2,
      ST_RANGE    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   // where a shift pivots
   typedef enum logic [1:0] {
      PT_POS   = 2'd0,
      PT_COUNT = 2'd1,
      PT_ZERO  = 2'd2,
      PT_HIT   = 2'd3
   } point_type;

   localparam int unsigned OP_W     = 3;
   localparam int unsigned POS_W    = 4;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned INDEX_W  = 4;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned REQ_W    = 40;
   localparam int unsigned RSP_W    = 16;

   typedef struct packed {
      logic       capture;
      logic       load;
      logic       shift_up;
      logic       shift_down;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       idx_en;
      point_type  point;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   pos_bad;
      logic   hit;
   } stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/bale_ctrl.sv =====
// controller: request handshake, operation decode and result valid
`timescale 1ns / 1ps
`default_nettype none

module bale_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   output logic                   rsp_tvalid,
   input  wire logic              rsp_tready,
   input  wire bale_pkg::stat_type stat,
   output bale_pkg::cmd_type      cmd
);
   import bale_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE  = 2'b01,
      S_APPLY = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd        = '0;
      cmd.point  = PT_POS;
      cmd.status = ST_OK;
      state_in   = state_ff;
      cmd.capture = req_tvalid && (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = S_IDLE;
               unique case (stat.op)
                  OP_PUSH_BACK: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        cmd.point    = PT_COUNT;
                        cmd.cnt_inc  = 1'b1;
                     end
                  end
                  OP_POP_BACK: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.cnt_dec = 1'b1;
                     end
                  end
                  OP_PUSH_FRONT: begin
                     if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        cmd.point    = PT_ZERO;
                        cmd.cnt_inc  = 1'b1;
                     end
                  end
                  OP_POP_FRONT: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else begin
                        cmd.shift_down = 1'b1;
                        cmd.point      = PT_ZERO;
                        cmd.cnt_dec    = 1'b1;
                     end
                  end
                  OP_INSERT: begin
                     // range is checked before full
                     if (stat.pos_bad) begin
                        cmd.status = ST_RANGE;
                     end else if (stat.full) begin
                        cmd.status = ST_FULL;
                     end else begin
                        cmd.shift_up = 1'b1;
                        cmd.point    = PT_POS;
                        cmd.cnt_inc  = 1'b1;
                     end
                  end
                  OP_ERASE: begin
                     if (stat.empty) begin
                        cmd.status = ST_EMPTY;
                     end else if (stat.pos_bad) begin
                        cmd.status = ST_RANGE;
                     end else begin
                        cmd.shift_down = 1'b1;
                        cmd.point      = PT_POS;
                        cmd.cnt_dec    = 1'b1;
                     end
                  end
                  OP_FIND: begin
                     if (stat.hit) begin
                        cmd.idx_en = 1'b1;
                     end else begin
                        cmd.status = ST_NOTFOUND;
                     end
                  end
                  OP_REMOVE: begin
                     if (stat.hit) begin
                        cmd.idx_en     = 1'b1;
                        cmd.shift_down = 1'b1;
                        cmd.point      = PT_HIT;
                        cmd.cnt_dec    = 1'b1;
                     end else begin
                        cmd.status = ST_NOTFOUND;
                     end
                  end
                  default: begin
                     cmd.status = ST_OK;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/bale_datapath.sv =====
// datapath: entry cells with per-cell compare and neighbor shift, count, result register
`timescale 1ns / 1ps
`default_nettype none

module bale_datapath #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic [bale_pkg::REQ_W-1:0] req_tdata,
   input  wire bale_pkg::cmd_type         cmd,
   output bale_pkg::stat_type             stat,
   output logic [bale_pkg::RSP_W-1:0]     rsp_tdata
);
   import bale_pkg::*;

   localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;
   localparam int unsigned QW = (CW > COUNT_W) ? CW : COUNT_W;

   logic [VALUE_W-1:0]  cell_ff [CAPACITY];
   logic [VALUE_W-1:0]  cell_in [CAPACITY];
   logic [CW-1:0]       count_ff, count_in;
   logic [CAPACITY-1:0] match_ff, match_in;
   op_type              op_ff;
   logic [POS_W-1:0]    pos_ff;
   logic [VALUE_W-1:0]  value_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [INDEX_W-1:0]  rsp_index_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;

   logic [CAPACITY-1:0] first_hit;
   logic [IW-1:0]       hit_idx;
   logic [IW-1:0]       point;
   logic [PW-1:0]       pos_ext, cnt_pext, idx_ext;
   logic [QW-1:0]       cnt_qext;

   // per-cell compare against the incoming value, limited to live entries
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match_in[i] = (cell_ff[i] == req_tdata[OP_W+POS_W +: VALUE_W]) &&
                       (CW'(i) < count_ff);
      end
   end

   // isolate lowest set bit, then encode its index
   assign first_hit = match_ff & (~match_ff + CAPACITY'(1));

   always_comb begin
      hit_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (first_hit[i]) begin
            hit_idx = hit_idx | IW'(i);
         end
      end
   end

   assign pos_ext  = PW'(pos_ff);
   assign cnt_pext = PW'(count_ff);

   assign stat.op      = op_ff;
   assign stat.empty   = (count_ff == '0);
   assign stat.full    = (count_ff == CW'(CAPACITY));
   assign stat.pos_bad = (pos_ext >= cnt_pext);
   assign stat.hit     = |match_ff;

   always_comb begin
      case (cmd.point)
         PT_POS:   point = pos_ext[IW-1:0];
         PT_COUNT: point = count_ff[IW-1:0];
         PT_HIT:   point = hit_idx;
         default:  point = '0;
      endcase
   end

   // shift up opens a gap at point for the value, shift down closes it
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cell_in[i] = cell_ff[i];
         if (cmd.shift_up) begin
            if (IW'(i) == point) begin
               cell_in[i] = value_ff;
            end else if ((i > 0) && (IW'(i) > point)) begin
               cell_in[i] = cell_ff[(i > 0) ? i - 1 : 0];
            end
         end else if (cmd.shift_down) begin
            if ((i + 1 < CAPACITY) && (IW'(i) >= point)) begin
               cell_in[i] = cell_ff[(i + 1 < CAPACITY) ? i + 1 : i];
            end
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign idx_ext  = cmd.idx_en ? PW'(hit_idx) : '0;
   assign cnt_qext = QW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.load) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= op_type'(req_tdata[OP_W-1:0]);
         pos_ff   <= req_tdata[OP_W +: POS_W];
         value_ff <= req_tdata[OP_W+POS_W +: VALUE_W];
         match_ff <= match_in;
      end
      if (cmd.load) begin
         for (int i = 0; i < CAPACITY; i++) begin
            cell_ff[i] <= cell_in[i];
         end
         rsp_status_ff <= cmd.status;
         rsp_index_ff  <= idx_ext[INDEX_W-1:0];
         rsp_count_ff  <= cnt_qext[COUNT_W-1:0];
      end
   end

   assign rsp_tdata = {4'b0000, rsp_count_ff, rsp_index_ff, rsp_status_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/bounded_array_list_engine.sv =====
// bounded array list engine: an accepted item is captured with the per-cell compare,
// then an update state does the priority pick and neighbor shift of all cells and
// registers the result, waiting while an earlier result is not yet taken
// the result register lets the next item be accepted while a result waits
// reset clears the entry count (list empty); entry cells hold unknown data
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine #(
   parameter int unsigned CAPACITY = 16
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   // operation[2:0], position[6:3], value[38:7], zero[39]
   input  wire logic [bale_pkg::REQ_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // status[2:0], found_index[6:3], entry_count[11:7], zero[15:12]
   output logic [bale_pkg::RSP_W-1:0]      rsp_tdata
);
   import bale_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   bale_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bale_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_tdata (rsp_tdata)
   );

endmodule

`default_nettype wire
